// File: hdl/sws_pkg.sv
// Shared types and constants for the go-back-N sliding window sender.
// Used by sws_dp, sws_ctrl and sliding_window_sender; depends on nothing.
`timescale 1ns / 1ps

package sws_pkg;

  // window depth; slots are taken from the low sequence bits, so keep it a power of two
  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int WIN_W  = $clog2(WINDOW + 1);

  // field widths
  localparam int SEQ_W    = 64;
  localparam int LEN_W    = 16;
  localparam int ETYPE_W  = 16;
  localparam int FTYPE_W  = 8;
  localparam int AWIN_W   = 32;
  localparam int FWIN_W   = 6;
  localparam int FSLOT_W  = 5;
  localparam int STALL_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // input commands
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RETX   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_LONG    = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ETHERTYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd3;

  // configuration reset values
  localparam logic [ETYPE_W-1:0] RST_ETHERTYPE = 16'd34997;
  localparam logic [FTYPE_W-1:0] RST_ACK_TYPE  = 8'd2;
  localparam logic [STALL_W-1:0] RST_TIMEOUT   = 16'd300;
  localparam logic [LEN_W-1:0]   RST_MAX_LEN   = 16'd1472;

  typedef struct packed {
    logic [1:0]         command;
    logic [LEN_W-1:0]   send_len;
    logic [ETYPE_W-1:0] frame_ethertype;
    logic [FTYPE_W-1:0] frame_type;
    logic               frame_complete;
    logic [SEQ_W-1:0]   ack_value;
    logic [AWIN_W-1:0]  ack_window;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         status;
    logic [SEQ_W-1:0]   frame_sequence;
    logic [SEQ_W-1:0]   frame_ack;
    logic [FWIN_W-1:0]  frame_window;
    logic [FSLOT_W-1:0] buffer_slot;
    logic [LEN_W-1:0]   frame_len;
    logic               last;
  } out_word_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_RPREP,
    S_RETX
  } ctrl_state_t;

  // output word source
  typedef enum logic [1:0] {
    OSEL_STATUS,
    OSEL_DATA,
    OSEL_RETX
  } osel_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       calc;
    logic       send;
    logic       ack;
    logic       stall_clr;
    logic       stall_set;
    logic       retx_init;
    logic       retx_step;
    logic       out_load;
    osel_t      out_sel;
    logic [2:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       frame_ok;
    logic       too_long;
    logic       full;
    logic       stall_hit;
    logic       outst_zero;
    logic       retx_last;
    logic       load_ok;
  } dp_stat_t;

endpackage

// File: hdl/sws_dp.sv
// Datapath of the sliding window sender: config registers, window state,
// frame length store and output register. Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  sws_pkg::in_word_t                   in_data,
  input  logic                                out_ready,
  input  sws_pkg::dp_cmd_t                    cmd,
  output sws_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  output sws_pkg::out_word_t                  out_data
);
  import sws_pkg::*;

  // configuration
  logic [ETYPE_W-1:0] cfg_etype_r;
  logic [FTYPE_W-1:0] cfg_atype_r;
  logic [STALL_W-1:0] cfg_timeout_r;
  logic [LEN_W-1:0]   cfg_maxlen_r;

  // captured input word
  in_word_t in_r;

  // window state
  logic [SEQ_W-1:0]   send_seq_r;
  logic [SEQ_W-1:0]   first_unacked_r;
  logic [WIN_W-1:0]   peer_win_r;
  logic [WIN_W-1:0]   outst_r;
  logic [STALL_W-1:0] stall_r;
  logic [SLOT_W-1:0]  cnt_r;

  // precomputed decisions
  logic [SEQ_W-1:0]   ack_clip_r;
  logic [WIN_W-1:0]   awin_r;
  logic               frame_ok_r;
  logic               too_long_r;
  logic [STALL_W-1:0] stall_inc_r;
  logic               stall_hit_r;

  // length store
  logic [LEN_W-1:0]   len_mem [WINDOW];
  logic [LEN_W-1:0]   len_q_r;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  retx_slot;

  logic               out_valid_r;
  out_word_t          out_r;
  out_word_t          out_nxt;
  logic [STALL_W-1:0] stall_inc;
  logic               ack_adv;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_etype_r   <= RST_ETHERTYPE;
      cfg_atype_r   <= RST_ACK_TYPE;
      cfg_timeout_r <= RST_TIMEOUT;
      cfg_maxlen_r  <= RST_MAX_LEN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ETHERTYPE: cfg_etype_r   <= cfg_wdata[ETYPE_W-1:0];
        REG_ACK_TYPE:  cfg_atype_r   <= cfg_wdata[FTYPE_W-1:0];
        REG_TIMEOUT:   cfg_timeout_r <= cfg_wdata[STALL_W-1:0];
        REG_MAX_LEN:   cfg_maxlen_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  // saturating stall increment
  assign stall_inc = (stall_r == {STALL_W{1'b1}}) ? stall_r : stall_r + 1'b1;

  // first stage: compares on the captured word
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ack_clip_r  <= (in_r.ack_value > send_seq_r) ? send_seq_r : in_r.ack_value;
      awin_r      <= (in_r.ack_window > AWIN_W'(WINDOW)) ? WIN_W'(WINDOW)
                                                          : WIN_W'(in_r.ack_window);
      frame_ok_r  <= (in_r.frame_ethertype == cfg_etype_r) &&
                     (in_r.frame_type == cfg_atype_r) && in_r.frame_complete;
      too_long_r  <= in_r.send_len > cfg_maxlen_r;
      stall_inc_r <= stall_inc;
      stall_hit_r <= stall_inc >= cfg_timeout_r;
    end
  end

  assign ack_adv = ack_clip_r > first_unacked_r;

  // window state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_seq_r      <= '0;
      first_unacked_r <= '0;
      peer_win_r      <= WIN_W'(WINDOW);
      outst_r         <= '0;
      stall_r         <= '0;
      cnt_r           <= '0;
    end else begin
      if (cmd.send) begin
        send_seq_r <= send_seq_r + 1'b1;
        outst_r    <= outst_r + 1'b1;
      end
      if (cmd.ack) begin
        peer_win_r <= awin_r;
        if (ack_adv) begin
          first_unacked_r <= ack_clip_r;
          outst_r         <= WIN_W'(send_seq_r - ack_clip_r);
        end
      end
      if (cmd.ack && ack_adv) begin
        stall_r <= '0;
      end else if (cmd.stall_clr) begin
        stall_r <= '0;
      end else if (cmd.stall_set) begin
        stall_r <= stall_inc_r;
      end
      if (cmd.retx_init) begin
        cnt_r <= '0;
      end else if (cmd.retx_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // length store, read one frame ahead during a retransmit run
  assign retx_slot = first_unacked_r[SLOT_W-1:0] + cnt_r;
  assign rd_addr   = cmd.retx_step ? retx_slot + 1'b1 : retx_slot;

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      len_mem[send_seq_r[SLOT_W-1:0]] <= in_r.send_len;
    end
    len_q_r <= len_mem[rd_addr];
  end

  // output word select
  always_comb begin
    out_nxt        = '0;
    out_nxt.kind   = KIND_STATUS;
    out_nxt.status = cmd.out_status;
    out_nxt.last   = 1'b1;
    case (cmd.out_sel)
      OSEL_DATA: begin
        out_nxt.kind           = KIND_NEW;
        out_nxt.status         = ST_OK;
        out_nxt.frame_sequence = send_seq_r;
        out_nxt.frame_ack      = first_unacked_r;
        out_nxt.frame_window   = FWIN_W'(peer_win_r);
        out_nxt.buffer_slot    = FSLOT_W'(send_seq_r[SLOT_W-1:0]);
        out_nxt.frame_len      = in_r.send_len;
      end
      OSEL_RETX: begin
        out_nxt.kind           = KIND_RETX;
        out_nxt.status         = ST_OK;
        out_nxt.frame_sequence = first_unacked_r + SEQ_W'(cnt_r);
        out_nxt.frame_ack      = first_unacked_r;
        out_nxt.frame_window   = FWIN_W'(peer_win_r);
        out_nxt.buffer_slot    = FSLOT_W'(retx_slot);
        out_nxt.frame_len      = len_q_r;
        out_nxt.last           = cmd.out_last;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  assign stat.command    = in_r.command;
  assign stat.frame_ok   = frame_ok_r;
  assign stat.too_long   = too_long_r;
  assign stat.full       = outst_r >= peer_win_r;
  assign stat.stall_hit  = stall_hit_r;
  assign stat.outst_zero = outst_r == '0;
  assign stat.retx_last  = ({1'b0, cnt_r} + 1'b1) == outst_r;
  assign stat.load_ok    = !out_valid_r || out_ready;

endmodule

// File: hdl/sws_ctrl.sv
// Controller of the sliding window sender: sequences capture, decision,
// single results and retransmit runs. Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sws_pkg::dp_stat_t stat,
  output sws_pkg::dp_cmd_t  cmd
);
  import sws_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.out_sel    = OSEL_STATUS;
    cmd.out_status = ST_OK;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.command)
          CMD_SEND: begin
            if (stat.too_long) begin
              cmd.out_status = ST_LONG;
            end else if (stat.full) begin
              cmd.out_status = ST_FULL;
            end else begin
              cmd.out_sel = OSEL_DATA;
            end
            if (stat.load_ok) begin
              cmd.out_load = 1'b1;
              cmd.send     = !stat.too_long && !stat.full;
              state_nxt    = S_IDLE;
            end
          end
          CMD_ACK: begin
            cmd.out_status = stat.frame_ok ? ST_OK : ST_IGNORED;
            if (stat.load_ok) begin
              cmd.out_load = 1'b1;
              cmd.ack      = stat.frame_ok;
              state_nxt    = S_IDLE;
            end
          end
          CMD_TICK: begin
            if (!stat.full) begin
              cmd.stall_clr = 1'b1;
              state_nxt     = S_IDLE;
            end else if (!stat.stall_hit) begin
              cmd.stall_set = 1'b1;
              state_nxt     = S_IDLE;
            end else if (stat.outst_zero) begin
              cmd.out_status = ST_TIMEOUT;
              if (stat.load_ok) begin
                cmd.out_load  = 1'b1;
                cmd.stall_clr = 1'b1;
                state_nxt     = S_IDLE;
              end
            end else begin
              cmd.stall_clr = 1'b1;
              cmd.retx_init = 1'b1;
              state_nxt     = S_RPREP;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RPREP: begin
        // first length read is in flight
        state_nxt = S_RETX;
      end
      S_RETX: begin
        cmd.out_sel  = OSEL_RETX;
        cmd.out_last = stat.retx_last;
        if (stat.load_ok) begin
          cmd.out_load  = 1'b1;
          cmd.retx_step = 1'b1;
          if (stat.retx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/sliding_window_sender.sv
// Top level of the go-back-N sliding window sender.
// Instantiates sws_ctrl and sws_dp; depends on sws_pkg.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_data  (sws_pkg::in_word_t)
//   out_    | output    | out_valid / out_ready  | out_data (sws_pkg::out_word_t)
//   cfg_    | input     | cfg_we                 | cfg_addr, cfg_wdata
//
// One word is handled at a time: capture in S_IDLE, compare in S_CALC and update in
// S_EXEC, where a result waits until the output register is free.
// A timeout run first reads the length store in S_RPREP, then emits one
// retransmitted word per cycle while out_ready stays high.
// A stalled output holds the controller in place; the output register lets a
// result wait while the next word is already being captured and compared.
// Reset is synchronous; no clearing pass is needed, the length store is
// read only at slots that were written.
`timescale 1ns / 1ps

module sliding_window_sender (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sws_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sws_pkg::out_word_t             out_data
);
  import sws_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, length store and output register
  sws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: dv/sws_checker.sv
// Scoreboard for the sliding window sender: mirrors config writes, predicts result words.
// Compares every accepted result word against the prediction; depends on sws_pkg.
`timescale 1ns / 1ps

module sws_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  sws_pkg::in_word_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  sws_pkg::out_word_t             out_data,
  output int                             errors,
  output int                             pending,
  output int                             results_seen,
  output int                             retx_seen,
  output logic [sws_pkg::SEQ_W-1:0]      sent_upto,
  output logic [sws_pkg::SEQ_W-1:0]      acked_upto
);
  import sws_pkg::*;

  // mirrored configuration
  logic [ETYPE_W-1:0] ethertype_reg;
  logic [FTYPE_W-1:0] acktype_reg;
  int                 timeout_reg;
  logic [LEN_W-1:0]   maxlen_reg;

  // mirrored sender state
  logic [SEQ_W-1:0] send_seq;
  logic [SEQ_W-1:0] first_unacked;
  int               peer_win;
  int               stall_cnt;
  logic [LEN_W-1:0] len_store [WINDOW];

  out_word_t frames_due[$];
  out_word_t want;
  int        fail_cnt;
  int        result_cnt;
  int        retx_cnt;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
    fail_cnt++;
  endtask

  task automatic queue_status(input logic [2:0] code);
    out_word_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = code;
    r.last = 1'b1;
    frames_due.push_back(r);
  endtask

  function automatic out_word_t frame_desc(input logic [1:0] k, input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] len);
    out_word_t r;
    r.kind = k;
    r.status = ST_OK;
    r.frame_sequence = seq;
    r.frame_ack = first_unacked;
    r.frame_window = FWIN_W'(peer_win);
    r.buffer_slot = FSLOT_W'(seq % WINDOW);
    r.frame_len = len;
    r.last = 1'b0;
    return r;
  endfunction

  // expected result words for one accepted input word
  task automatic forecast_frames(input in_word_t w);
    logic [SEQ_W-1:0] outst;
    logic [SEQ_W-1:0] ackv;
    logic [SEQ_W-1:0] seq;
    logic             full;
    int               n;
    out_word_t        r;
    outst = send_seq - first_unacked;
    full = outst >= SEQ_W'(peer_win);
    case (w.command)
      CMD_SEND: begin
        if (w.send_len > maxlen_reg) queue_status(ST_LONG);
        else if (full) queue_status(ST_FULL);
        else begin
          len_store[int'(send_seq % WINDOW)] = w.send_len;
          r = frame_desc(KIND_NEW, send_seq, w.send_len);
          r.last = 1'b1;
          frames_due.push_back(r);
          send_seq++;
        end
      end
      CMD_ACK: begin
        if (w.frame_ethertype != ethertype_reg || w.frame_type != acktype_reg ||
            !w.frame_complete) begin
          queue_status(ST_IGNORED);
        end else begin
          // acks past the last sent frame count as acking everything
          ackv = (w.ack_value > send_seq) ? send_seq : w.ack_value;
          if (ackv > first_unacked) begin
            first_unacked = ackv;
            stall_cnt = 0;
          end
          peer_win = (w.ack_window > WINDOW) ? WINDOW : int'(w.ack_window);
          queue_status(ST_OK);
        end
      end
      CMD_TICK: begin
        if (!full) stall_cnt = 0;
        else begin
          if (stall_cnt < 65535) stall_cnt++;
          if (stall_cnt >= timeout_reg) begin
            stall_cnt = 0;
            if (outst == 0) queue_status(ST_TIMEOUT);
            else begin
              // go back: resend the whole outstanding run
              n = (outst > WINDOW) ? WINDOW : int'(outst);
              for (int i = 0; i < n; i++) begin
                seq = first_unacked + i;
                r = frame_desc(KIND_RETX, seq, len_store[int'(seq % WINDOW)]);
                r.last = (i == n - 1);
                frames_due.push_back(r);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ethertype_reg = RST_ETHERTYPE;
      acktype_reg = RST_ACK_TYPE;
      timeout_reg = int'(RST_TIMEOUT);
      maxlen_reg = RST_MAX_LEN;
      send_seq = '0;
      first_unacked = '0;
      peer_win = WINDOW;
      stall_cnt = 0;
      for (int i = 0; i < WINDOW; i++) len_store[i] = '0;
      frames_due.delete();
    end else begin
      // config mirror
      if (cfg_we) begin
        case (cfg_addr)
          REG_ETHERTYPE: ethertype_reg = cfg_wdata;
          REG_ACK_TYPE:  acktype_reg = cfg_wdata[FTYPE_W-1:0];
          REG_TIMEOUT:   timeout_reg = int'(cfg_wdata);
          REG_MAX_LEN:   maxlen_reg = cfg_wdata;
          default: ;
        endcase
      end
      // result side
      if (out_valid && out_ready) begin
        result_cnt++;
        if (out_data.kind == KIND_RETX) retx_cnt++;
        if (frames_due.size() == 0) begin
          report("unexpected result word", out_data.frame_sequence, '0);
        end else begin
          want = frames_due.pop_front();
          if (out_data.kind !== want.kind) report("kind", out_data.kind, want.kind);
          if (out_data.status !== want.status) report("status", out_data.status, want.status);
          if (out_data.frame_sequence !== want.frame_sequence)
            report("frame_sequence", out_data.frame_sequence, want.frame_sequence);
          if (out_data.frame_ack !== want.frame_ack)
            report("frame_ack", out_data.frame_ack, want.frame_ack);
          if (out_data.frame_window !== want.frame_window)
            report("frame_window", out_data.frame_window, want.frame_window);
          if (out_data.buffer_slot !== want.buffer_slot)
            report("buffer_slot", out_data.buffer_slot, want.buffer_slot);
          if (out_data.frame_len !== want.frame_len)
            report("frame_len", out_data.frame_len, want.frame_len);
          if (out_data.last !== want.last) report("last", out_data.last, want.last);
        end
      end
      // input side
      if (in_valid && in_ready) forecast_frames(in_data);
    end
    errors <= fail_cnt;
    pending <= frames_due.size();
    results_seen <= result_cnt;
    retx_seen <= retx_cnt;
    sent_upto <= send_seq;
    acked_upto <= first_unacked;
  end

endmodule

// File: dv/testbench.sv
// Top of the sliding window sender testbench: clock, reset, stimulus and verdict.
// Depends on sws_pkg, sliding_window_sender and sws_checker.
`timescale 1ns / 1ps

module testbench;
  import sws_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;

  int               errors;
  int               pending;
  int               results_seen;
  int               retx_seen;
  logic [SEQ_W-1:0] sent_upto;
  logic [SEQ_W-1:0] acked_upto;

  // stimulus-side copy of the settings
  logic [ETYPE_W-1:0] cur_etype;
  logic [FTYPE_W-1:0] cur_atype;
  int                 cur_timeout;
  int                 cur_maxlen;
  bit                 gaps_on;
  int                 n_items;
  int                 n_settings;
  int                 hold_cnt;
  int                 ready_roll;

  sliding_window_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sws_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .retx_seen    (retx_seen),
    .sent_upto    (sent_upto),
    .acked_upto   (acked_upto)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver back-pressure: mostly short stalls, some long ones, long open stretches
  always @(posedge clk) begin
    if (hold_cnt == 0) begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_ready <= 1'b1;
        hold_cnt = $urandom_range(1, 12);
      end else if (ready_roll < 65) begin
        out_ready <= 1'b1;
        hold_cnt = $urandom_range(40, 120);
      end else if (ready_roll < 95) begin
        out_ready <= 1'b0;
        hold_cnt = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        hold_cnt = $urandom_range(15, 50);
      end
    end else begin
      hold_cnt--;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // every field random, then the caller fixes what matters
  function automatic in_word_t rand_word(input logic [1:0] cmd);
    in_word_t w;
    w.command = cmd;
    w.send_len = LEN_W'($urandom);
    w.frame_ethertype = ETYPE_W'($urandom);
    w.frame_type = FTYPE_W'($urandom);
    w.frame_complete = 1'($urandom);
    w.ack_value = {$urandom, $urandom};
    w.ack_window = $urandom;
    return w;
  endfunction

  function automatic in_word_t send_word(input int len);
    in_word_t w;
    w = rand_word(CMD_SEND);
    w.send_len = LEN_W'(len);
    return w;
  endfunction

  function automatic in_word_t ack_word(input logic [SEQ_W-1:0] val,
                                        input logic [AWIN_W-1:0] win);
    in_word_t w;
    w = rand_word(CMD_ACK);
    w.frame_ethertype = cur_etype;
    w.frame_type = cur_atype;
    w.frame_complete = 1'b1;
    w.ack_value = val;
    w.ack_window = win;
    return w;
  endfunction

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, cur_maxlen);
    if (roll < 90) return cur_maxlen;
    return int'(LEN_W'($urandom));
  endfunction

  // ack point: partial, full, stale, ahead of what was sent, or anything
  function automatic logic [SEQ_W-1:0] pick_ack();
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    span = int'(sent_upto - acked_upto);
    if (roll < 45) return acked_upto + $urandom_range(0, span);
    if (roll < 65) return sent_upto;
    if (roll < 80) return (acked_upto > 3) ? acked_upto - $urandom_range(0, 3) : '0;
    if (roll < 90) return sent_upto + $urandom_range(1, 5);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AWIN_W-1:0] pick_win();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 4);
    if (roll < 70) return $urandom_range(5, 40);
    if (roll < 85) return WINDOW;
    return $urandom;
  endfunction

  // one word across the input handshake, after an optional gap
  task automatic push(input in_word_t w);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.command != CMD_UNUSED) n_items++;
  endtask

  // wait until every expected word has come and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] etype, input logic [7:0] atype,
                            input logic [15:0] tmo, input logic [15:0] mlen);
    cfg_we <= 1'b1;
    cfg_addr <= REG_ETHERTYPE;
    cfg_wdata <= etype;
    @(posedge clk);
    cfg_addr <= REG_ACK_TYPE;
    cfg_wdata <= {8'd0, atype};
    @(posedge clk);
    cfg_addr <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_addr <= REG_MAX_LEN;
    cfg_wdata <= mlen;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_etype = etype;
    cur_atype = atype;
    cur_timeout = int'(tmo);
    cur_maxlen = int'(mlen);
    n_settings++;
  endtask

  // ack everything and open the window, fill it, then tick toward a timeout
  task automatic run_burst(input int win, input int nsend);
    int nt;
    push(ack_word(sent_upto + 8, AWIN_W'(win)));
    repeat (nsend) push(send_word(pick_len()));
    if (cur_timeout > 8) nt = $urandom_range(1, 8);
    else nt = $urandom_range(cur_timeout, 2 * cur_timeout + 1);
    repeat (nt) push(rand_word(CMD_TICK));
  endtask

  initial begin
    in_word_t w;
    int       roll;
    int       start;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    out_ready <= 1'b0;
    rst_n <= 1'b0;
    hold_cnt = 0;
    n_items = 0;
    n_settings = 1;
    gaps_on = 1'b1;
    cur_etype = RST_ETHERTYPE;
    cur_atype = RST_ACK_TYPE;
    cur_timeout = int'(RST_TIMEOUT);
    cur_maxlen = int'(RST_MAX_LEN);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: length limits, each ack check, clamping, full window, stale ack
    push(send_word(0));
    push(send_word(RST_MAX_LEN));
    push(send_word(RST_MAX_LEN + 1));
    push(send_word(16'hFFFF));
    w = ack_word(64'd1, 32'd5);
    w.frame_ethertype = RST_ETHERTYPE ^ 16'h0001;
    push(w);
    w = ack_word(64'd1, 32'd5);
    w.frame_type = RST_ACK_TYPE ^ 8'h80;
    push(w);
    w = ack_word(64'd1, 32'd5);
    w.frame_complete = 1'b0;
    push(w);
    push(ack_word(64'd1, 32'hFFFF_FFFF));
    push(ack_word('1, 32'd0));
    push(send_word(100));
    push(rand_word(CMD_TICK));
    push(rand_word(CMD_UNUSED));
    push(ack_word(64'd0, 32'd1));
    push(send_word(7));
    push(send_word(8));
    push(rand_word(CMD_TICK));
    push(ack_word(64'd3, 32'd32));
    push(rand_word(CMD_TICK));
    push(send_word(RST_MAX_LEN));

    // random phases, one setting each
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_config(16'h0000, 8'h00, 16'd1, 16'hFFFF);
        1: set_config(16'hFFFF, 8'hFF, 16'd2, 16'd0);
        2: set_config(RST_ETHERTYPE, RST_ACK_TYPE, 16'hFFFF, RST_MAX_LEN);
        3: set_config(16'($urandom), 8'($urandom), 16'($urandom_range(1, 4)),
                      16'($urandom_range(1, 2000)));
        4: set_config(16'($urandom), 8'($urandom), 16'd3, 16'hFFFF);
        default: set_config(RST_ETHERTYPE, RST_ACK_TYPE, 16'd1, RST_MAX_LEN);
      endcase
      gaps_on = (ph != 2);
      start = n_items;
      // full-window retransmit run, and a timeout with nothing outstanding
      if (ph == 0) begin
        run_burst(WINDOW, WINDOW + 1);
        run_burst(0, 1);
      end
      while (n_items - start < 55) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) run_burst($urandom_range(0, WINDOW), $urandom_range(1, WINDOW + 1));
        else if (roll < 45) push(send_word(pick_len()));
        else if (roll < 65) push(ack_word(pick_ack(), pick_win()));
        else if (roll < 85) push(rand_word(CMD_TICK));
        else if (roll < 90) push(rand_word(CMD_ACK));
        else if (roll < 95) push(rand_word(CMD_SEND));
        else push(rand_word(CMD_UNUSED));
      end
    end

    drain();
    $display("covered %0d words under %0d settings: %0d results checked, %0d retransmitted",
             n_items, n_settings, results_seen, retx_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
